/* hdl/ksod_pkg.sv */
`timescale 1ns / 1ps
package ksod_pkg;

   // field widths
   localparam int unsigned CH_W     = 4;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CNT_W    = 24;
   localparam int unsigned SUM_W    = 40;
   localparam int unsigned SQ_W     = 56;
   localparam int unsigned BOUND_W  = 48;
   localparam int unsigned SIGMA_W  = 4;
   localparam int unsigned TOT_W    = 32;

   localparam logic [CNT_W-1:0]   COUNT_MAX   = 24'hFFFFFF;
   localparam logic [CNT_W-1:0]   MIN_SAMPLES = 24'd2;
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd4;
   localparam logic [TOT_W-1:0]   TOT_MAX     = 32'hFFFFFFFF;

   localparam logic KIND_LEARN = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   // queue between front and back
   localparam int unsigned QDEPTH = 2;

   typedef enum logic {
      OP_LEARN,
      OP_CHECK
   } op_type;

   typedef struct packed {
      logic                       kind;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in_vector;
   } req_type;

   typedef struct packed {
      logic             is_outlier;
      logic [TOT_W-1:0] checks_total;
      logic [TOT_W-1:0] outliers_total;
      logic [TOT_W-1:0] elements_total;
   } rsp_type;

   // classified item as queued
   typedef struct packed {
      op_type                     op;
      logic                       chan_ok;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } item_type;

   // per-channel statistics
   typedef struct packed {
      logic [CNT_W-1:0]          count;
      logic signed [SUM_W-1:0]   sum;
      logic [SQ_W-1:0]           sq;
      logic signed [BOUND_W-1:0] lo;
      logic signed [BOUND_W-1:0] hi;
   } chan_type;

endpackage

/* hdl/ksod_front.sv */
`timescale 1ns / 1ps
module ksod_front
   import ksod_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   item_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wp_ff, rp_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                accept, push, pop;
   logic                chan_ok;
   item_type            cls;

   // classify: learn on a missing channel is dropped here
   always_comb begin
      chan_ok     = ({5'b0, req_data.channel} < 9'(CHANNELS));
      cls.op      = (req_data.kind == KIND_CHECK) ? OP_CHECK : OP_LEARN;
      cls.chan_ok = chan_ok;
      cls.channel = req_data.channel;
      cls.sample  = req_data.sample;
      cls.last    = req_data.last_in_vector;
   end

   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (cls.op == OP_CHECK || chan_ok);
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = q_ff[rp_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (wp_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (rp_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

/* hdl/ksod_back.sv */
`timescale 1ns / 1ps
module ksod_back
   import ksod_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SIGMA_W-1:0] sigma,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MULA,
      ST_MULB,
      ST_SQRT,
      ST_DIVM,
      ST_DIVS,
      ST_WRITE
   } state_type;

   state_type              state_ff;
   item_type               itm_ff;
   chan_type               mem [CHANNELS];
   logic [CHANNELS-1:0]    vld_ff;
   chan_type               rd_ff;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_idx, wr_idx;
   logic                   mem_we;
   chan_type               mem_wdata;

   // learn datapath registers
   logic [CNT_W-1:0]          n_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [79:0]               acc_ff, mcand_ff, pa_ff;
   logic [39:0]               mplier_ff;
   logic [5:0]                step_ff;
   logic [111:0]              rad_ff;
   logic [55:0]               root_ff;
   logic [57:0]               srem_ff;
   logic [55:0]               dvd_ff;
   logic [CNT_W-1:0]          drem_ff;
   logic signed [BOUND_W-1:0] mean_ff;
   logic [55:0]               sd_ff;

   // counters and result
   logic             flag_ff;
   logic [TOT_W-1:0] chk_ff, outl_ff, elem_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   // combinational helpers
   chan_type                  entry;
   logic signed [BOUND_W-1:0] v48;
   logic [31:0]               sq32;
   logic [CNT_W-1:0]          n_inc;
   logic signed [SUM_W-1:0]   sum_inc;
   logic [SQ_W-1:0]           sq_inc;
   logic [SUM_W-1:0]          sum_mag;
   logic                      bad, flag_nx;
   logic [TOT_W-1:0]          elem_nx, chk_nx, outl_nx;
   logic [79:0]               acc_nx, diff;
   logic [59:0]               cur, trial;
   logic                      sq_ge;
   logic [57:0]               srem_nx;
   logic [55:0]               root_nx;
   logic [24:0]               dr;
   logic                      d_ge;
   logic [CNT_W-1:0]          drem_nx;
   logic [55:0]               dvd_nx, qm;
   logic [59:0]               spread;
   logic                      rsp_load;

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rd_idx    = IDX_W'({4'b0, q_item.channel});
   assign wr_idx    = IDX_W'({4'b0, itm_ff.channel});
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // last check item of a vector loads the result register
   assign rsp_load  = (state_ff == ST_EXEC) && (itm_ff.op == OP_CHECK) && itm_ff.last &&
                      (!rsp_valid_ff || !rsp_stall);

   // statistics memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= mem_wdata;
      end
      if (q_pop) begin
         rd_ff <= mem[rd_idx];
      end
   end

   // item arithmetic
   always_comb begin
      entry   = rd_vld_ff ? rd_ff : '0;
      v48     = {{16{itm_ff.sample[15]}}, itm_ff.sample, 16'b0};
      sq32    = 32'(itm_ff.sample * itm_ff.sample);
      n_inc   = entry.count + 1'b1;
      sum_inc = entry.sum + SUM_W'(itm_ff.sample);
      sq_inc  = entry.sq + SQ_W'(sq32);
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      bad     = !itm_ff.chan_ok || (entry.count < MIN_SAMPLES) ||
                (v48 < entry.lo) || (v48 > entry.hi);
      flag_nx = flag_ff || bad;
      elem_nx = (elem_ff == TOT_MAX) ? elem_ff : elem_ff + 1'b1;
      chk_nx  = (chk_ff == TOT_MAX) ? chk_ff : chk_ff + 1'b1;
      outl_nx = (flag_nx && outl_ff != TOT_MAX) ? outl_ff + 1'b1 : outl_ff;
   end

   // shift-add multiply, root and divide steps
   always_comb begin
      acc_nx  = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      diff    = (pa_ff >= acc_nx) ? pa_ff - acc_nx : '0;
      cur     = {srem_ff, rad_ff[111:110]};
      trial   = {2'b0, root_ff, 2'b01};
      sq_ge   = (cur >= trial);
      srem_nx = sq_ge ? 58'(cur - trial) : cur[57:0];
      root_nx = {root_ff[54:0], sq_ge};
      dr      = {drem_ff, dvd_ff[55]};
      d_ge    = (dr >= {1'b0, n_ff});
      drem_nx = d_ge ? CNT_W'(dr - {1'b0, n_ff}) : dr[CNT_W-1:0];
      dvd_nx  = {dvd_ff[54:0], d_ge};
      qm      = dvd_nx + 56'(drem_nx != '0);
      spread  = sd_ff * sigma;
   end

   // memory write data
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = '0;
      if (state_ff == ST_EXEC && itm_ff.op == OP_LEARN && entry.count == '0) begin
         mem_we          = 1'b1;
         mem_wdata.count = CNT_W'(1);
         mem_wdata.sum   = SUM_W'(itm_ff.sample);
         mem_wdata.sq    = SQ_W'(sq32);
         mem_wdata.lo    = v48;
         mem_wdata.hi    = v48;
      end else if (state_ff == ST_WRITE) begin
         mem_we          = 1'b1;
         mem_wdata.count = n_ff;
         mem_wdata.sum   = sum_ff;
         mem_wdata.sq    = sq_ff;
         mem_wdata.lo    = mean_ff - BOUND_W'(spread);
         mem_wdata.hi    = mean_ff + BOUND_W'(spread);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         flag_ff      <= 1'b0;
         chk_ff       <= '0;
         outl_ff      <= '0;
         elem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  itm_ff    <= q_item;
                  rd_vld_ff <= vld_ff[rd_idx];
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (itm_ff.op == OP_CHECK) begin
                  if (!itm_ff.last) begin
                     elem_ff  <= elem_nx;
                     flag_ff  <= flag_nx;
                     state_ff <= ST_IDLE;
                  end else if (rsp_load) begin
                     elem_ff                <= elem_nx;
                     chk_ff                 <= chk_nx;
                     outl_ff                <= outl_nx;
                     flag_ff                <= 1'b0;
                     rsp_ff.is_outlier      <= flag_nx;
                     rsp_ff.checks_total    <= chk_nx;
                     rsp_ff.outliers_total  <= outl_nx;
                     rsp_ff.elements_total  <= elem_nx;
                     state_ff               <= ST_IDLE;
                  end
               end else if (entry.count == '0 || entry.count >= COUNT_MAX) begin
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff      <= n_inc;
                  sum_ff    <= sum_inc;
                  sq_ff     <= sq_inc;
                  acc_ff    <= '0;
                  mcand_ff  <= 80'(sq_inc);
                  mplier_ff <= 40'(n_inc);
                  step_ff   <= 6'(CNT_W - 1);
                  state_ff  <= ST_MULA;
               end
            end
            ST_MULA: begin
               if (step_ff == '0) begin
                  pa_ff     <= acc_nx;
                  acc_ff    <= '0;
                  mcand_ff  <= 80'(sum_mag);
                  mplier_ff <= sum_mag;
                  step_ff   <= 6'(SUM_W - 1);
                  state_ff  <= ST_MULB;
               end else begin
                  acc_ff    <= acc_nx;
                  mcand_ff  <= {mcand_ff[78:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[39:1]};
                  step_ff   <= step_ff - 1'b1;
               end
            end
            ST_MULB: begin
               acc_ff    <= acc_nx;
               mcand_ff  <= {mcand_ff[78:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[39:1]};
               if (step_ff == '0) begin
                  rad_ff   <= {diff, 32'b0};
                  root_ff  <= '0;
                  srem_ff  <= '0;
                  step_ff  <= 6'd55;
                  state_ff <= ST_SQRT;
               end else begin
                  step_ff  <= step_ff - 1'b1;
               end
            end
            ST_SQRT: begin
               rad_ff  <= {rad_ff[109:0], 2'b00};
               srem_ff <= srem_nx;
               root_ff <= root_nx;
               if (step_ff == '0) begin
                  dvd_ff   <= {sum_mag, 16'b0};
                  drem_ff  <= '0;
                  step_ff  <= 6'd55;
                  state_ff <= ST_DIVM;
               end else begin
                  step_ff  <= step_ff - 1'b1;
               end
            end
            ST_DIVM: begin
               if (step_ff == '0) begin
                  // floor toward minus infinity for a negative sum
                  mean_ff  <= sum_ff[SUM_W-1] ? BOUND_W'(-qm) : dvd_nx[BOUND_W-1:0];
                  dvd_ff   <= root_ff;
                  drem_ff  <= '0;
                  step_ff  <= 6'd55;
                  state_ff <= ST_DIVS;
               end else begin
                  dvd_ff   <= dvd_nx;
                  drem_ff  <= drem_nx;
                  step_ff  <= step_ff - 1'b1;
               end
            end
            ST_DIVS: begin
               dvd_ff  <= dvd_nx;
               drem_ff <= drem_nx;
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  sd_ff    <= dvd_nx;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hdl/k_sigma_outlier_detector_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                              Moves
// req       in         req_valid, req_stall, req_data     one sample item
// rsp       out        rsp_valid, rsp_stall, rsp_data     one vector verdict
// csr       in         csr_wr_en, csr_wr_data             sigma multiplier
//
// A check item or a first or ignored learn item passes through ST_IDLE and ST_EXEC.
// A learn item that updates bounds then runs a shift-add multiply for each of two
// products, a bit-serial square root and two restoring divides before ST_WRITE.
// A two-entry queue decouples intake from the back end; req_stall rises when full.
// Synchronous reset clears the valid bits, counters and queue; no clearing pass.
module k_sigma_outlier_detector_core
   import ksod_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [SIGMA_W-1:0] csr_wr_data
);

   logic [SIGMA_W-1:0] sigma_ff;
   logic               q_valid, q_pop;
   item_type           q_item;

   // sigma multiplier register
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
      end else if (csr_wr_en) begin
         sigma_ff <= csr_wr_data;
      end
   end

   ksod_front #(.CHANNELS(CHANNELS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   ksod_back #(.CHANNELS(CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .sigma     (sigma_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
